[rtl/chtdh_pkg.sv]
// Package for the counting hash table with double hashing.
// Request and result structs, opcode, status, register index and state codes.
// Used by every file in rtl.
package chtdh_pkg;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_TAKE   = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_ZERO   = 2'd3
  } status_e;

  localparam logic [0:0] REG_TABLE_SIZE = 1'b0;
  localparam logic [0:0] REG_HASH_MULT  = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  status;
    logic [31:0] count_value;
    logic [12:0] distinct_keys;
  } res_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [63:0] data;
  } cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_DONE
  } state_e;

endpackage

[rtl/counting_hash_table_double_hashing_top.sv]
// Top level of the counting hash table with double hashing.
// Key and count memories, hash multiply, serial modulo and probe sequencer.
// Depends on chtdh_pkg.
//
//  channel  direction  handshake            payload
//  cfg      in         cfg_valid/cfg_ready  cfg_i    (index, data)
//  req      in         in_valid/in_ready    req_i    (opcode, key)
//  res      out        out_valid/out_ready  res_o    (found, status, count, distinct)
//
// After reset a clearing pass writes SLOT_DEPTH entries, one a cycle, before
// the first request is taken. A request runs S_MUL0 to S_MUL2 (multiply),
// S_DIV (bit-serial modulo), then S_READ (memory read) and S_CHECK (compare
// with write-back) per probe; key zero skips the memories in S_MUL0. A request
// is taken only when idle and the output register is empty or being emptied.
module counting_hash_table_double_hashing_top #(
  parameter int SLOT_DEPTH = 4096,
  parameter int COUNT_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  chtdh_pkg::cfg_t cfg_i,
  input  logic            in_valid,
  output logic            in_ready,
  input  chtdh_pkg::req_t req_i,
  output logic            out_valid,
  input  logic            out_ready,
  output chtdh_pkg::res_t res_o
);
  import chtdh_pkg::*;

  localparam int AW = $clog2(SLOT_DEPTH);
  localparam int SW = AW + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [12:0] PLACED_MAX = 13'd8191;

  logic [63:0]         slot_key_mem [SLOT_DEPTH];
  logic [COUNT_BITS-1:0] slot_cnt_mem [SLOT_DEPTH];

  state_e state_q, state_d;
  logic [12:0] tsize_q;
  logic [63:0] mult_q;
  logic [1:0]  op_q;
  logic [63:0] key_q;
  logic [31:0] pp_q [4];
  logic [63:0] h_q;
  logic [6:0]  bit_q;
  logic [SW-1:0] r1_q, r2_q;
  logic [SW-1:0] size_q;
  logic [AW-1:0] pos_q, step_q;
  logic [SW-1:0] iter_q;
  logic [AW-1:0] clr_q;
  logic [63:0] rkey_q;
  logic [COUNT_BITS-1:0] rcnt_q;
  logic        zp_q;
  logic [COUNT_BITS-1:0] zc_q;
  logic [12:0] placed_q;
  logic        out_valid_q;
  res_t        res_q;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0] wr_key;
  logic [COUNT_BITS-1:0] wr_cnt;
  logic        res_load;
  res_t        res_new;
  logic [63:0] prod_ll;

  logic [SW-1:0] size_eff;
  always_comb begin
    if (tsize_q < 13'd3) size_eff = SW'(3);
    else if (32'(tsize_q) > SLOT_DEPTH) size_eff = SW'(SLOT_DEPTH);
    else size_eff = SW'(tsize_q);
  end

  op_e op_n;
  assign op_n = (op_e'(op_q) == OP_SPARE) ? OP_SEARCH : op_e'(op_q);

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
  assign out_valid = out_valid_q;
  assign res_o     = res_q;

  assign prod_ll = key_q[31:0] * mult_q[31:0];

  // serial remainder step for both moduli
  logic [SW:0] t1, t2;
  assign t1 = {r1_q, h_q[63]};
  assign t2 = {r2_q, h_q[63]};

  logic [SW:0] pos_sum;
  assign pos_sum = {2'b0, pos_q} + {2'b0, step_q};

  logic [COUNT_BITS-1:0] cur_cnt;
  logic upd_slot;
  always_comb begin
    state_d  = state_q;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_key   = key_q;
    wr_cnt   = rcnt_q;
    res_load = 1'b0;
    res_new  = '0;
    cur_cnt  = '0;
    upd_slot = 1'b0;
    res_new.distinct_keys = placed_q;
    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_key  = '0;
        wr_cnt  = '0;
        if (32'(clr_q) == SLOT_DEPTH - 1) state_d = S_IDLE;
      end
      S_IDLE: if (in_valid && in_ready) state_d = S_MUL0;
      S_MUL0: begin
        if (key_q == '0) begin
          res_load = 1'b1;
          cur_cnt  = zc_q;
          state_d  = S_IDLE;
          if (!zp_q) begin
            if (op_n == OP_INSERT) res_new.count_value = 32'd1;
            else res_new.status = ST_ABSENT;
          end else begin
            res_new.found = 1'b1;
            if (op_n == OP_TAKE) begin
              if (zc_q == '0) res_new.status = ST_ZERO;
              else cur_cnt = zc_q - 1'b1;
            end else if (zc_q != CNT_MAX) cur_cnt = zc_q + 1'b1;
            res_new.count_value = 32'(cur_cnt);
          end
        end else state_d = S_MUL1;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_DIV;
      S_DIV:  if (bit_q == 7'd63) state_d = S_READ;
      S_READ: state_d = S_CHECK;
      S_CHECK: begin
        if (rkey_q == '0) begin
          if (op_n == OP_INSERT) begin
            wr_en  = 1'b1;
            wr_cnt = COUNT_BITS'(1);
            res_new.count_value = 32'd1;
            res_new.distinct_keys = (placed_q == PLACED_MAX) ? placed_q : placed_q + 1'b1;
          end else res_new.status = ST_ABSENT;
          res_load = 1'b1;
          state_d  = S_IDLE;
        end else if (rkey_q == key_q) begin
          res_new.found = 1'b1;
          cur_cnt = rcnt_q;
          if (op_n == OP_TAKE) begin
            if (rcnt_q == '0) res_new.status = ST_ZERO;
            else begin cur_cnt = rcnt_q - 1'b1; upd_slot = 1'b1; end
          end else if (rcnt_q != CNT_MAX) begin
            cur_cnt = rcnt_q + 1'b1; upd_slot = 1'b1;
          end
          wr_en  = upd_slot;
          wr_cnt = cur_cnt;
          res_new.count_value = 32'(cur_cnt);
          res_load = 1'b1;
          state_d  = S_IDLE;
        end else if (iter_q == size_q - 1'b1) begin
          res_new.status = ST_FULL;
          res_load = 1'b1;
          state_d  = S_IDLE;
        end else state_d = S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      tsize_q     <= 13'd4093;
      mult_q      <= 64'h9E3779B97F4A7C15;
      clr_q       <= '0;
      zp_q        <= 1'b0;
      zc_q        <= '0;
      placed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) begin
        if (cfg_i.index == REG_TABLE_SIZE) tsize_q <= cfg_i.data[12:0];
        else mult_q <= cfg_i.data;
      end
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (res_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
      if (state_q == S_MUL0 && key_q == '0) begin
        if (!zp_q && op_n == OP_INSERT) begin
          zp_q <= 1'b1;
          zc_q <= COUNT_BITS'(1);
        end else if (zp_q) zc_q <= cur_cnt;
      end
      if (state_q == S_CHECK) placed_q <= res_new.distinct_keys;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_new;
    if (in_valid && in_ready) begin
      op_q  <= req_i.opcode;
      key_q <= req_i.key;
    end
    unique case (state_q)
      S_MUL0: begin
        pp_q[0] <= prod_ll[31:0];
        pp_q[1] <= prod_ll[63:32];
        pp_q[2] <= key_q[31:0] * mult_q[63:32];
        pp_q[3] <= key_q[63:32] * mult_q[31:0];
        size_q  <= size_eff;
      end
      S_MUL1: pp_q[1] <= pp_q[1] + pp_q[2] + pp_q[3];
      S_MUL2: begin
        h_q   <= {pp_q[1], pp_q[0]};
        bit_q <= '0;
        r1_q  <= '0;
        r2_q  <= '0;
      end
      S_DIV: begin
        h_q   <= {h_q[62:0], 1'b0};
        bit_q <= bit_q + 1'b1;
        r1_q  <= (t1 >= {1'b0, size_q}) ? SW'(t1 - {1'b0, size_q}) : SW'(t1);
        r2_q  <= (t2 >= {1'b0, size_q - 1'b1}) ? SW'(t2 - {1'b0, size_q - 1'b1}) : SW'(t2);
        if (bit_q == 7'd63) begin
          pos_q  <= AW'((t1 >= {1'b0, size_q}) ? t1 - {1'b0, size_q} : t1);
          step_q <= AW'(((t2 >= {1'b0, size_q - 1'b1}) ? t2 - {1'b0, size_q - 1'b1} : t2)
                        + 1'b1);
          iter_q <= '0;
        end
      end
      S_CHECK: begin
        pos_q  <= (pos_sum >= {1'b0, size_q}) ? AW'(pos_sum - {1'b0, size_q}) : AW'(pos_sum);
        iter_q <= iter_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_key_mem[wr_addr] <= wr_key;
      slot_cnt_mem[wr_addr] <= wr_cnt;
    end
    rkey_q <= slot_key_mem[pos_q];
    rcnt_q <= slot_cnt_mem[pos_q];
  end

endmodule
